// ===== hw/rtl/otb_pkg.sv =====
// Shared types and constants of the Otsu threshold binarizer.
package otb_pkg;

  typedef enum logic [1:0] {
    OP_CNT,
    OP_LAST,
    OP_BIN
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] grey;
  } cmd_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] level;
    logic [7:0] grey_out;
  } res_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DRAIN,
    S_SUM_RD,
    S_SUM_AC,
    S_T_RD,
    S_T_AC,
    S_T_CHK,
    S_P,
    S_Q,
    S_DIFF,
    S_NUM,
    S_DEN,
    S_LHS,
    S_RHS,
    S_NEXT,
    S_DONE
  } st_t;

  localparam logic KIND_LEVEL = 1'b0;
  localparam logic KIND_PIX   = 1'b1;

  localparam logic [7:0] PIX_HI   = 8'd255;
  localparam logic [7:0] PIX_LO   = 8'd0;
  localparam logic [7:0] LAST_BIN = 8'd255;
  localparam logic [7:0] LAST_CUT = 8'd254;

  localparam int CMDQ_DEPTH = 4;
  localparam int RESQ_DEPTH = 2;

endpackage

// ===== hw/rtl/otb_fifo.sv =====
// Small synchronous FIFO used for the request and result queues.
module otb_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);
  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wp_r;
  logic [AW-1:0]    rp_r;
  logic [AW:0]      cnt_r;
  logic             do_push;
  logic             do_pop;

  assign full    = (cnt_r == (AW+1)'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= wp_r + 1'b1;
      if (do_pop) rp_r <= rp_r + 1'b1;
      if (do_push && !do_pop) cnt_r <= cnt_r + 1'b1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= din;
  end

endmodule

// ===== hw/rtl/otb_front.sv =====
// Front end: classifies incoming pixel requests and queues them.
module otb_front import otb_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  logic       func,
  input  logic [7:0] grey,
  input  logic       last,
  output logic       full,
  input  logic       cmd_pop,
  output cmd_t       cmd,
  output logic       cmd_empty
);
  cmd_t cmd_in;

  always_comb begin
    cmd_in.grey = grey;
    if (func) cmd_in.op = OP_BIN;
    else if (last) cmd_in.op = OP_LAST;
    else cmd_in.op = OP_CNT;
  end

  otb_fifo #(
    .WIDTH($bits(cmd_t)),
    .DEPTH(CMDQ_DEPTH)
  ) u_cmdq (
    .clk  (clk),
    .rst_n(rst_n),
    .push (push),
    .din  (cmd_in),
    .full (full),
    .pop  (cmd_pop),
    .dout (cmd),
    .empty(cmd_empty)
  );

endmodule

// ===== hw/rtl/otb_mul.sv =====
// Iterative shift-add multiplier, one multiplier bit per cycle.
module otb_mul #(
  parameter int AW = 16,
  parameter int BW = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [AW-1:0]    a,
  input  logic [BW-1:0]    b,
  output logic             done,
  output logic [AW+BW-1:0] prod
);
  logic [AW+BW-1:0] a_r;
  logic [BW-1:0]    b_r;
  logic [AW+BW-1:0] acc_r;
  logic             busy_r;

  assign done = busy_r && (b_r == '0);
  assign prod = acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (done) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= (AW+BW)'(a);
      b_r   <= b;
      acc_r <= '0;
    end else if (busy_r && !done) begin
      if (b_r[0]) acc_r <= acc_r + a_r;
      a_r <= a_r << 1;
      b_r <= b_r >> 1;
    end
  end

endmodule

// ===== hw/rtl/otb_back.sv =====
// Back end: histogram memory, binarizing and the Otsu threshold search.
module otb_back import otb_pkg::*; #(
  parameter int COUNT_BITS = 21
) (
  input  logic clk,
  input  logic rst_n,
  input  cmd_t cmd,
  input  logic cmd_empty,
  output logic cmd_pop,
  input  logic res_full,
  output logic res_push,
  output res_t res
);
  localparam int CB   = COUNT_BITS;
  localparam int NW   = CB + 8;
  localparam int SW   = CB + 16;
  localparam int PW   = SW + NW;
  localparam int NUMW = 2 * PW;
  localparam int DW   = 2 * NW;
  localparam int CW   = NUMW + DW;
  localparam int MAW  = NUMW;
  localparam int MBW  = PW;

  logic [CB-1:0] mem [256];
  logic [255:0]  vld_r;
  logic [CB-1:0] rd_data_r;
  logic          rd_vld_r;
  logic [7:0]    ra;

  st_t           state_r, state_nxt;
  logic [7:0]    idx_r, idx_nxt;
  logic [NW-1:0] n_r, n_nxt;
  logic [SW-1:0] s_r, s_nxt;
  logic [NW-1:0] w0_r, w0_nxt;
  logic [SW-1:0] s0_r, s0_nxt;
  logic [PW-1:0] p_r, p_nxt;
  logic [PW-1:0] q_r, q_nxt;
  logic [NUMW-1:0] num_r, num_nxt;
  logic [DW-1:0] den_r, den_nxt;
  logic [CW-1:0] lhs_r, lhs_nxt;
  logic [NUMW-1:0] bnum_r, bnum_nxt;
  logic [DW-1:0] bden_r, bden_nxt;
  logic [7:0]    best_r, best_nxt;
  logic          have_r, have_nxt;
  logic [7:0]    cut_r, cut_nxt;
  logic          p1_vld_r, p1_vld_nxt;
  logic [7:0]    p1_addr_r, p1_addr_nxt;
  logic          wb_vld_r;
  logic [7:0]    wb_addr_r;
  logic [CB-1:0] wb_val_r;
  logic          clr;

  logic [CB-1:0]   old_cnt;
  logic [CB-1:0]   inc_cnt;
  logic [CB-1:0]   hval;
  logic [CB+7:0]   ih;
  logic [NW-1:0]   w1;
  logic [PW-1:0]   diff;
  logic            mul_start;
  logic [MAW-1:0]  mul_a;
  logic [MBW-1:0]  mul_b;
  logic            mul_done;
  logic [MAW+MBW-1:0] mul_prod;

  otb_mul #(.AW(MAW), .BW(MBW)) u_mul (
    .clk  (clk),
    .rst_n(rst_n),
    .start(mul_start),
    .a    (mul_a),
    .b    (mul_b),
    .done (mul_done),
    .prod (mul_prod)
  );

  // count write-back stage, forwarding the previous write to the same bin
  assign old_cnt = (wb_vld_r && wb_addr_r == p1_addr_r) ? wb_val_r :
                   (rd_vld_r ? rd_data_r : '0);
  assign inc_cnt = (&old_cnt) ? old_cnt : old_cnt + CB'(1);
  assign hval    = rd_vld_r ? rd_data_r : '0;
  assign ih      = idx_r * hval;
  assign w1      = n_r - w0_r;
  assign diff    = (p_r >= q_r) ? (p_r - q_r) : (q_r - p_r);

  always_ff @(posedge clk) begin
    rd_data_r <= mem[ra];
    if (p1_vld_r) mem[p1_addr_r] <= inc_cnt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
      wb_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= vld_r[ra];
      wb_vld_r <= p1_vld_r;
      if (clr) vld_r <= '0;
      else if (p1_vld_r) vld_r[p1_addr_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    wb_addr_r <= p1_addr_r;
    wb_val_r  <= inc_cnt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      p1_vld_r <= 1'b0;
      have_r   <= 1'b0;
      cut_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      p1_vld_r <= p1_vld_nxt;
      have_r   <= have_nxt;
      cut_r    <= cut_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r     <= idx_nxt;
    n_r       <= n_nxt;
    s_r       <= s_nxt;
    w0_r      <= w0_nxt;
    s0_r      <= s0_nxt;
    p_r       <= p_nxt;
    q_r       <= q_nxt;
    num_r     <= num_nxt;
    den_r     <= den_nxt;
    lhs_r     <= lhs_nxt;
    bnum_r    <= bnum_nxt;
    bden_r    <= bden_nxt;
    best_r    <= best_nxt;
    p1_addr_r <= p1_addr_nxt;
  end

  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    n_nxt       = n_r;
    s_nxt       = s_r;
    w0_nxt      = w0_r;
    s0_nxt      = s0_r;
    p_nxt       = p_r;
    q_nxt       = q_r;
    num_nxt     = num_r;
    den_nxt     = den_r;
    lhs_nxt     = lhs_r;
    bnum_nxt    = bnum_r;
    bden_nxt    = bden_r;
    best_nxt    = best_r;
    have_nxt    = have_r;
    cut_nxt     = cut_r;
    p1_vld_nxt  = 1'b0;
    p1_addr_nxt = p1_addr_r;
    clr         = 1'b0;
    ra          = idx_r;
    cmd_pop     = 1'b0;
    res_push    = 1'b0;
    res         = '0;
    mul_start   = 1'b0;
    mul_a       = '0;
    mul_b       = '0;
    case (state_r)
      S_IDLE: begin
        if (!cmd_empty) begin
          case (cmd.op)
            OP_BIN: begin
              if (!res_full) begin
                cmd_pop      = 1'b1;
                res_push     = 1'b1;
                res.kind     = KIND_PIX;
                res.grey_out = (cmd.grey > cut_r) ? PIX_HI : PIX_LO;
              end
            end
            OP_CNT: begin
              cmd_pop     = 1'b1;
              ra          = cmd.grey;
              p1_vld_nxt  = 1'b1;
              p1_addr_nxt = cmd.grey;
            end
            OP_LAST: begin
              cmd_pop     = 1'b1;
              ra          = cmd.grey;
              p1_vld_nxt  = 1'b1;
              p1_addr_nxt = cmd.grey;
              state_nxt   = S_DRAIN;
            end
            default: begin
              cmd_pop = 1'b1;
            end
          endcase
        end
      end
      S_DRAIN: begin
        n_nxt     = '0;
        s_nxt     = '0;
        idx_nxt   = '0;
        state_nxt = S_SUM_RD;
      end
      S_SUM_RD: begin
        state_nxt = S_SUM_AC;
      end
      S_SUM_AC: begin
        n_nxt = n_r + NW'(hval);
        s_nxt = s_r + SW'(ih);
        if (idx_r == LAST_BIN) begin
          idx_nxt   = '0;
          w0_nxt    = '0;
          s0_nxt    = '0;
          have_nxt  = 1'b0;
          best_nxt  = '0;
          state_nxt = S_T_RD;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_SUM_RD;
        end
      end
      S_T_RD: begin
        state_nxt = S_T_AC;
      end
      S_T_AC: begin
        w0_nxt    = w0_r + NW'(hval);
        s0_nxt    = s0_r + SW'(ih);
        state_nxt = S_T_CHK;
      end
      S_T_CHK: begin
        if (w0_r == '0 || w1 == '0) begin
          state_nxt = S_NEXT;
        end else begin
          mul_start = 1'b1;
          mul_a     = MAW'(s0_r);
          mul_b     = MBW'(n_r);
          state_nxt = S_P;
        end
      end
      S_P: begin
        if (mul_done) begin
          p_nxt     = mul_prod[PW-1:0];
          mul_start = 1'b1;
          mul_a     = MAW'(s_r);
          mul_b     = MBW'(w0_r);
          state_nxt = S_Q;
        end
      end
      S_Q: begin
        if (mul_done) begin
          q_nxt     = mul_prod[PW-1:0];
          state_nxt = S_DIFF;
        end
      end
      S_DIFF: begin
        mul_start = 1'b1;
        mul_a     = MAW'(diff);
        mul_b     = diff;
        state_nxt = S_NUM;
      end
      S_NUM: begin
        if (mul_done) begin
          num_nxt   = mul_prod[NUMW-1:0];
          mul_start = 1'b1;
          mul_a     = MAW'(w0_r);
          mul_b     = MBW'(w1);
          state_nxt = S_DEN;
        end
      end
      S_DEN: begin
        if (mul_done) begin
          den_nxt = mul_prod[DW-1:0];
          if (!have_r) begin
            have_nxt  = 1'b1;
            bnum_nxt  = num_r;
            bden_nxt  = mul_prod[DW-1:0];
            best_nxt  = idx_r;
            state_nxt = S_NEXT;
          end else begin
            mul_start = 1'b1;
            mul_a     = num_r;
            mul_b     = MBW'(bden_r);
            state_nxt = S_LHS;
          end
        end
      end
      S_LHS: begin
        if (mul_done) begin
          lhs_nxt   = mul_prod[CW-1:0];
          mul_start = 1'b1;
          mul_a     = bnum_r;
          mul_b     = MBW'(den_r);
          state_nxt = S_RHS;
        end
      end
      S_RHS: begin
        if (mul_done) begin
          if (lhs_r > mul_prod[CW-1:0]) begin
            bnum_nxt = num_r;
            bden_nxt = den_r;
            best_nxt = idx_r;
          end
          state_nxt = S_NEXT;
        end
      end
      S_NEXT: begin
        if (idx_r == LAST_CUT) begin
          state_nxt = S_DONE;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_T_RD;
        end
      end
      S_DONE: begin
        if (!res_full) begin
          res_push  = 1'b1;
          res.kind  = KIND_LEVEL;
          res.level = best_r;
          cut_nxt   = best_r;
          clr       = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/otsu_threshold_binarizer.sv =====
// Top level of the Otsu threshold binarizer.
// Usage:
//   Input queue: drive in_func, in_grey_in, in_last with in_push; a request is
//   taken when in_push is high and in_full is low. func 0 counts the pixel into
//   the 256-bin histogram; with in_last set it also starts the level search.
//   func 1 binarizes the pixel against the stored level (above gives 255).
//   Result queue: while out_empty is low the oldest result is on out_kind,
//   out_level, out_grey_out; out_pop takes it.
// Throughput: counted and binarized pixels go at one per cycle while no level
//   search runs and the result queue has room; binarized pixels are registered
//   in the request queue and then in the result queue.
// Level search: the histogram is totalled, then per level with both classes
//   non-empty up to six products on a shift-add multiplier taking one cycle per
//   multiplier bit. Requests wait meanwhile; in_full rises once the queue fills.
// Reset: histogram is empty and the stored level is 0; nothing is waiting.
// If out_pop stays low, results wait in a two-entry queue and the back end
//   holds off, which in turn backs the input queue up.
module otsu_threshold_binarizer import otb_pkg::*; #(
  parameter int COUNT_BITS = 21
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic       in_func,
  input  logic [7:0] in_grey_in,
  input  logic       in_last,
  output logic       out_empty,
  input  logic       out_pop,
  output logic       out_kind,
  output logic [7:0] out_level,
  output logic [7:0] out_grey_out
);
  cmd_t cmd;
  logic cmd_empty;
  logic cmd_pop;
  logic res_full;
  logic res_push;
  res_t res_in;
  res_t res_q;

  otb_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_push),
    .func     (in_func),
    .grey     (in_grey_in),
    .last     (in_last),
    .full     (in_full),
    .cmd_pop  (cmd_pop),
    .cmd      (cmd),
    .cmd_empty(cmd_empty)
  );

  otb_back #(.COUNT_BITS(COUNT_BITS)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .cmd_empty(cmd_empty),
    .cmd_pop  (cmd_pop),
    .res_full (res_full),
    .res_push (res_push),
    .res      (res_in)
  );

  otb_fifo #(
    .WIDTH($bits(res_t)),
    .DEPTH(RESQ_DEPTH)
  ) u_resq (
    .clk  (clk),
    .rst_n(rst_n),
    .push (res_push),
    .din  (res_in),
    .full (res_full),
    .pop  (out_pop),
    .dout (res_q),
    .empty(out_empty)
  );

  assign out_kind     = res_q.kind;
  assign out_level    = res_q.level;
  assign out_grey_out = res_q.grey_out;

endmodule

// ===== verif/tb_otsu_threshold_binarizer.sv =====
// Testbench for the Otsu threshold binarizer: random frames and pixels checked against a model.
`timescale 1ns / 1ps

module tb_otsu_threshold_binarizer;
  import otb_pkg::*;

  localparam int CNT_BITS  = 21;
  localparam int CNT_MAX   = (1 << CNT_BITS) - 1;
  localparam int N_ITEMS   = 1700;
  localparam int LIMIT     = 4000000;
  localparam int HOLD_LEN  = 3000;

  typedef logic [191:0] wide_t;

  typedef struct {
    logic       func;
    logic [7:0] grey;
    logic       last;
    logic       sync;
  } pixel_req_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_func = 1'b0;
  logic [7:0] in_grey_in = '0;
  logic in_last = 1'b0;
  logic out_pop = 1'b0;
  logic in_full, out_empty, out_kind;
  logic [7:0] out_level, out_grey_out;

  pixel_req_t req_q[$];
  res_t       want_q[$];
  int unsigned hist[256];
  int unsigned pix_total;
  logic [7:0]  cut;
  int errors = 0;
  int accepted = 0;
  int levels_seen = 0;
  int pixels_seen = 0;
  int cycles = 0;
  int tx_gap = 0;
  int rx_gap = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int wide_frames = 0;

  otsu_threshold_binarizer #(.COUNT_BITS(CNT_BITS)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full),
    .in_func(in_func), .in_grey_in(in_grey_in), .in_last(in_last),
    .out_empty(out_empty), .out_pop(out_pop),
    .out_kind(out_kind), .out_level(out_level), .out_grey_out(out_grey_out)
  );

  always #6 clk = ~clk;

  function automatic logic [7:0] otsu_level();
    wide_t n, s, w0, s0, w1, p, q, diff, num, den, best_num, best_den;
    bit have;
    logic [7:0] best;
    n = '0;
    s = '0;
    w0 = '0;
    s0 = '0;
    best_num = '0;
    best_den = '0;
    have = 1'b0;
    best = '0;
    for (int i = 0; i < 256; i++) begin
      n += wide_t'(hist[i]);
      s += wide_t'(i) * wide_t'(hist[i]);
    end
    for (int t = 0; t < 255; t++) begin
      w0 += wide_t'(hist[t]);
      s0 += wide_t'(t) * wide_t'(hist[t]);
      w1 = n - w0;
      if (w0 == 0 || w1 == 0) continue;
      p = s0 * n;
      q = s * w0;
      diff = (p >= q) ? p - q : q - p;
      num = diff * diff;
      den = w0 * w1;
      if (!have || num * best_den > best_num * den) begin
        have = 1'b1;
        best_num = num;
        best_den = den;
        best = t[7:0];
      end
    end
    return best;
  endfunction

  task automatic predict_pixel(input pixel_req_t r);
    res_t e;
    if (r.func) begin
      e.kind = KIND_PIX;
      e.level = '0;
      e.grey_out = (r.grey > cut) ? PIX_HI : PIX_LO;
      want_q.push_back(e);
      return;
    end
    if (hist[r.grey] < CNT_MAX) hist[r.grey]++;
    if (pix_total < CNT_MAX) pix_total++;
    if (!r.last) return;
    cut = otsu_level();
    for (int i = 0; i < 256; i++) hist[i] = 0;
    pix_total = 0;
    e.kind = KIND_LEVEL;
    e.level = cut;
    e.grey_out = '0;
    want_q.push_back(e);
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
    end else begin
      automatic bit busy = in_push && in_full;
      automatic pixel_req_t r;
      if (in_push && !in_full) begin
        r.func = in_func;
        r.grey = in_grey_in;
        r.last = in_last;
        r.sync = 1'b0;
        predict_pixel(r);
        accepted++;
      end
      if (!busy) begin
        if (req_q.size() > 0 && req_q[0].sync) begin
          if (want_q.size() == 0 && !(in_push && !in_full)) void'(req_q.pop_front());
          in_push <= 1'b0;
        end else if (tx_gap > 0) begin
          tx_gap--;
          in_push <= 1'b0;
        end else if (req_q.size() > 0) begin
          r = req_q.pop_front();
          in_func <= r.func;
          in_grey_in <= r.grey;
          in_last <= r.last;
          in_push <= 1'b1;
          tx_gap = pick_gap();
        end else begin
          in_push <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, once
  always @(posedge clk) begin
    if (rst_n && !hold_done && accepted >= 900) begin
      hold_left <= HOLD_LEN;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        if (want_q.size() == 0) begin
          $error("unexpected result kind=%0d level=%0d grey_out=%0d",
                 out_kind, out_level, out_grey_out);
          errors++;
        end else begin
          automatic res_t e = want_q.pop_front();
          if (out_kind !== e.kind) begin
            $error("kind: expected %0d, got %0d", e.kind, out_kind);
            errors++;
          end
          if (out_level !== e.level) begin
            $error("level: expected %0d, got %0d", e.level, out_level);
            errors++;
          end
          if (out_grey_out !== e.grey_out) begin
            $error("grey_out: expected %0d, got %0d", e.grey_out, out_grey_out);
            errors++;
          end
          if (e.kind == KIND_LEVEL) levels_seen++;
          else pixels_seen++;
        end
      end
      if (hold_left > 0) begin
        out_pop <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
        rx_gap = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("** otsu_threshold_binarizer: FAILED **");
      $finish;
    end
  end

  task automatic add(input logic func, input logic [7:0] grey, input logic last);
    pixel_req_t r;
    r.func = func;
    r.grey = grey;
    r.last = last;
    r.sync = 1'b0;
    req_q.push_back(r);
  endtask

  task automatic add_sync();
    pixel_req_t r;
    r.func = 1'b0;
    r.grey = '0;
    r.last = 1'b0;
    r.sync = 1'b1;
    req_q.push_back(r);
  endtask

  task automatic add_frame(input int len, input int lo, input int span);
    for (int i = 0; i < len; i++)
      add(1'b0, 8'((lo + $urandom_range(0, span)) % 256), i == len - 1);
  endtask

  task automatic add_bins(input int len);
    for (int i = 0; i < len; i++)
      add(1'b1, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  int total;

  initial begin
    for (int i = 0; i < 256; i++) hist[i] = 0;
    pix_total = 0;
    cut = '0;

    // stored level 0 after reset
    add(1'b1, 8'd0, 1'b0);
    add(1'b1, 8'd1, 1'b0);
    add(1'b1, 8'd255, 1'b1);
    // single pixel frame: every threshold has an empty class
    add(1'b0, 8'd255, 1'b1);
    add(1'b1, 8'd0, 1'b0);
    // symmetric clusters, tie goes to the lowest level; last on func 1 ignored
    add(1'b0, 8'd10, 1'b0);
    add(1'b1, 8'd128, 1'b1);
    add(1'b0, 8'd10, 1'b0);
    add(1'b0, 8'd12, 1'b0);
    add(1'b0, 8'd12, 1'b1);
    add(1'b1, 8'd10, 1'b0);
    add(1'b1, 8'd11, 1'b0);
    // extremes 0 and 255 in one frame
    add(1'b0, 8'd0, 1'b0);
    add(1'b0, 8'd255, 1'b0);
    add(1'b0, 8'd0, 1'b1);
    add(1'b1, 8'd0, 1'b0);
    add(1'b1, 8'd254, 1'b0);
    add(1'b1, 8'd255, 1'b0);
    add_sync();

    total = req_q.size();
    while (total < N_ITEMS) begin
      automatic int r = $urandom_range(0, 99);
      automatic int before_n = req_q.size();
      if (r < 65) begin
        add_frame($urandom_range(2, 30), $urandom_range(0, 255), $urandom_range(0, 15));
        add_bins($urandom_range(5, 40));
      end else if (r < 70 && wide_frames < 2) begin
        add_frame($urandom_range(10, 40), 0, 255);
        wide_frames++;
      end else if (r < 90) begin
        add_bins($urandom_range(1, 20));
      end else if (r < 95) begin
        add_frame(1, $urandom_range(0, 255), 0);
      end else begin
        add_sync();
      end
      total += req_q.size() - before_n;
    end
    // long binarize stretch so the receiver hold-off backs up the input
    add_bins(60);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    wait (req_q.size() == 0);
    @(posedge clk);
    while (in_push) @(posedge clk);
    while (want_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    if (want_q.size() != 0) begin
      $error("%0d expected results never arrived", want_q.size());
      errors++;
    end
    $display("covered %0d accepted requests: %0d frame levels, %0d binarized pixels",
             accepted, levels_seen, pixels_seen);
    $display("including tie, empty-class, extreme-range frames and a %0d-cycle hold-off",
             HOLD_LEN);
    if (errors == 0) begin
      $display("** otsu_threshold_binarizer: PASSED **");
    end else begin
      $display("** otsu_threshold_binarizer: FAILED **");
    end
    $finish;
  end

endmodule
